### rtl/rgam_pkg.sv
// rgam_pkg: shared types and constants of the ramped-gain audio mixer.
// Holds the configuration register set, the queue entry format and widths.
// No dependencies.
package rgam_pkg;

    // Channel limits
    localparam int MAX_CHANNELS = 8;
    localparam int POS_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W        = 6;

    // Datapath widths
    localparam int SAMPLE_W     = 16;
    localparam int WHOLE_W      = 15;
    localparam int START_W      = 16;
    localparam int ACC_W        = 32;
    localparam int COUNT_W      = 4;
    localparam int GAIN_W       = 18;
    localparam int PROD_W       = SAMPLE_W + GAIN_W;
    localparam int GAIN_SHIFT   = 12;
    localparam int SUM_W        = PROD_W - GAIN_SHIFT + 1;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    // Reset values
    localparam logic [WHOLE_W-1:0] GAIN_UNITY    = 15'h1000;
    localparam logic [COUNT_W-1:0] COUNT_DEFAULT = 4'd2;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_WHOLE_FIRST  = 3'd0,
        CFG_GAIN_WHOLE_SECOND = 3'd1,
        CFG_RAMP_START_FIRST  = 3'd2,
        CFG_RAMP_START_SECOND = 3'd3,
        CFG_RAMP_STEP_FIRST   = 3'd4,
        CFG_RAMP_STEP_SECOND  = 3'd5,
        CFG_CHANNEL_COUNT     = 3'd6
    } cfg_index_t;

    // Configuration register set
    typedef struct packed {
        logic [WHOLE_W-1:0] gain_whole_first;
        logic [WHOLE_W-1:0] gain_whole_second;
        logic [START_W-1:0] ramp_start_first;
        logic [START_W-1:0] ramp_start_second;
        logic [ACC_W-1:0]   ramp_step_first;
        logic [ACC_W-1:0]   ramp_step_second;
        logic [COUNT_W-1:0] channel_count;
    } cfg_t;

    // One classified sample waiting for the multiply-mix back end
    typedef struct packed {
        logic [SAMPLE_W-1:0] source_sample;
        logic [SAMPLE_W-1:0] mix_sample;
        logic [GAIN_W-1:0]   gain;
    } queue_item_t;

endpackage

### rtl/ramped_gain_audio_mixer.sv
// ramped_gain_audio_mixer: top level, configuration registers, front end,
// queue and back end. Depends on rgam_pkg, rgam_front, rgam_queue, rgam_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes source_sample, mix_sample and
//   block_start. Output channel (out_valid/out_ready) returns mixed_sample,
//   one result per input, in order. Set block_start on the first sample of a
//   block to reload the ramp accumulators and restart the frame position.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; there is no read-back.
//   Throughput: one sample per cycle while the queue is not full; the links
//   between samples are the frame position and the 32-bit ramp accumulator
//   add in the front end, done in the accept cycle. The queue entry is
//   written at the accept edge, then multiply stage, then output register.
//   Reset: accumulators and frame position clear, gains return to unity,
//   ramps to zero and the channel count to two.
//   Receiver stall: the output register holds its result, the multiply stage
//   and the two-entry queue fill, and in_ready drops once the queue is full.
module ramped_gain_audio_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] source_sample,
    input  logic [15:0] mix_sample,
    input  logic        block_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] mixed_sample,
    input  logic        cfg_we,
    input  logic [rgam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rgam_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rgam_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        push, queue_full, pop, q_not_empty;
    queue_item_t push_item, pop_item;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_WHOLE_FIRST:  cfg_next.gain_whole_first  = cfg_data[WHOLE_W-1:0];
                CFG_GAIN_WHOLE_SECOND: cfg_next.gain_whole_second = cfg_data[WHOLE_W-1:0];
                CFG_RAMP_START_FIRST:  cfg_next.ramp_start_first  = cfg_data[START_W-1:0];
                CFG_RAMP_START_SECOND: cfg_next.ramp_start_second = cfg_data[START_W-1:0];
                CFG_RAMP_STEP_FIRST:   cfg_next.ramp_step_first   = cfg_data[ACC_W-1:0];
                CFG_RAMP_STEP_SECOND:  cfg_next.ramp_step_second  = cfg_data[ACC_W-1:0];
                CFG_CHANNEL_COUNT:     cfg_next.channel_count     = cfg_data[COUNT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_whole_first  <= GAIN_UNITY;
            cfg_reg.gain_whole_second <= GAIN_UNITY;
            cfg_reg.ramp_start_first  <= '0;
            cfg_reg.ramp_start_second <= '0;
            cfg_reg.ramp_step_first   <= '0;
            cfg_reg.ramp_step_second  <= '0;
            cfg_reg.channel_count     <= COUNT_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rgam_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .source_sample (source_sample),
        .mix_sample    (mix_sample),
        .block_start   (block_start),
        .push          (push),
        .push_item     (push_item),
        .queue_full    (queue_full)
    );

    rgam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    rgam_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_item       (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample)
    );

endmodule

### rtl/rgam_front.sv
// rgam_front: accepts samples, tracks frame position and ramp accumulators,
// and attaches the gain of each sample. Depends on rgam_pkg.
module rgam_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rgam_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          source_sample,
    input  logic [15:0]          mix_sample,
    input  logic                 block_start,
    output logic                 push,
    output rgam_pkg::queue_item_t push_item,
    input  logic                 queue_full
);
    import rgam_pkg::*;

    logic [ACC_W-1:0] acc_first_reg, acc_first_next;
    logic [ACC_W-1:0] acc_second_reg, acc_second_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [CMP_W-1:0] eff;
    logic [POS_W-1:0] pos_cur;
    logic [ACC_W-1:0] base_first, base_second;
    logic             stereo, last, use_second, upd_first, upd_second;
    logic [WHOLE_W-1:0] whole_sel;
    logic [ACC_W-1:0] acc_sel;
    logic             accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // Effective channel count: zero acts as one, large counts clamp
    always_comb
    begin
        if (cfg.channel_count == '0)
            eff = CMP_W'(1);
        else if (CMP_W'(cfg.channel_count) > CMP_W'(MAX_CHANNELS))
            eff = CMP_W'(MAX_CHANNELS);
        else
            eff = CMP_W'(cfg.channel_count);
    end

    // Block start reloads accumulators and position before use
    assign base_first  = block_start ? ACC_W'(cfg.ramp_start_first)  : acc_first_reg;
    assign base_second = block_start ? ACC_W'(cfg.ramp_start_second) : acc_second_reg;
    assign pos_cur     = block_start ? '0 : pos_reg;

    assign stereo     = (eff == CMP_W'(2));
    assign last       = (CMP_W'(pos_cur) + CMP_W'(1)) >= eff;
    assign use_second = stereo && (pos_cur == POS_W'(1));
    assign upd_second = use_second;
    assign upd_first  = (stereo && (pos_cur == '0)) || (!use_second && last);

    // Gain: whole part plus signed upper half of the accumulator
    assign whole_sel = use_second ? cfg.gain_whole_second : cfg.gain_whole_first;
    assign acc_sel   = use_second ? base_second : base_first;

    always_comb
    begin
        push_item.source_sample = source_sample;
        push_item.mix_sample    = mix_sample;
        push_item.gain          = GAIN_W'({3'b000, whole_sel})
                                + {{(GAIN_W-16){acc_sel[ACC_W-1]}}, acc_sel[ACC_W-1:16]};
    end

    // Next state
    always_comb
    begin
        acc_first_next  = acc_first_reg;
        acc_second_next = acc_second_reg;
        pos_next        = pos_reg;
        if (accept)
        begin
            acc_first_next  = upd_first  ? base_first  + cfg.ramp_step_first  : base_first;
            acc_second_next = upd_second ? base_second + cfg.ramp_step_second : base_second;
            pos_next        = last ? '0 : pos_cur + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_first_reg  <= '0;
            acc_second_reg <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            acc_first_reg  <= acc_first_next;
            acc_second_reg <= acc_second_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

### rtl/rgam_queue.sv
// rgam_queue: two-entry queue between the front end and the back end.
// Depends on rgam_pkg for the entry format.
module rgam_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rgam_pkg::queue_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output rgam_pkg::queue_item_t pop_item
);
    import rgam_pkg::*;

    queue_item_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/rgam_back.sv
// rgam_back: multiply stage then shift, mix-add and saturate into the
// output register. Depends on rgam_pkg.
module rgam_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  rgam_pkg::queue_item_t q_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           mixed_sample
);
    import rgam_pkg::*;

    logic                       prod_valid_reg, prod_valid_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [SAMPLE_W-1:0]        mix_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        mixed_reg, mixed_next;

    logic                       out_load, prod_load;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [SUM_W-1:0]    sum;

    // Stall control: each stage loads when empty or when it drains
    assign out_load  = !out_valid_reg || out_ready;
    assign prod_load = !prod_valid_reg || out_load;
    assign pop       = q_not_empty && prod_load;

    // Multiply stage
    assign prod_next = PROD_W'($signed(q_item.source_sample)) * PROD_W'($signed(q_item.gain));
    assign prod_valid_next = prod_load ? q_not_empty : prod_valid_reg;

    // Floor shift, mix add, saturate
    assign shifted = prod_reg >>> GAIN_SHIFT;
    assign sum     = SUM_W'(shifted) + SUM_W'($signed(mix_reg));

    always_comb
    begin
        if (sum > SUM_W'(32767))
            mixed_next = 16'h7FFF;
        else if (sum < -SUM_W'(32768))
            mixed_next = 16'h8000;
        else
            mixed_next = sum[SAMPLE_W-1:0];
    end

    assign out_valid_next = out_load ? prod_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg <= prod_next;
            mix_reg  <= q_item.mix_sample;
        end
        if (out_load && prod_valid_reg)
            mixed_reg <= mixed_next;
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;

endmodule

### rtl/rgam_checker.sv
// rgam_checker: port-level checks of the mixer, bound to the top level.
// Depends on ramped_gain_audio_mixer port names only.
module rgam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] mixed_sample
);

    logic [3:0] pending_reg, pending_next;
    logic       in_take, out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // Requests accepted but not yet delivered
    assign pending_next = pending_reg + 4'(in_take) - 4'(out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 4'd0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mixed_sample))
        else $error("result changed while stalled");

    // No result without an outstanding request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result with no outstanding request");

    // Queue, multiply stage and output register bound the backlog
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("more requests in flight than storage");

    // An empty block always takes input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 4'd0 |-> in_ready)
        else $error("idle block refused a request");

endmodule

bind ramped_gain_audio_mixer rgam_checker u_rgam_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mixed_sample (mixed_sample)
);
